// File: rtl/nsts_pkg.sv
// Shared types and constants for the named slot table store.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package nsts_pkg;

	// table geometry
	localparam int SLOTS         = 32;
	localparam int SLOT_W        = 5;
	localparam int NAME_MAX      = 31;   // bytes kept per name
	localparam int NAME_LEN_W    = 5;
	localparam int NAME_IDX_W    = 5;
	localparam int CONTENT_MAX   = 255;  // bytes kept per content
	localparam int CLEN_W        = 8;
	localparam int OFF_W         = 8;
	localparam int CONT_ADDR_W   = SLOT_W + OFF_W;
	localparam int COUNT_W       = 6;
	localparam int BYTE_W        = 8;

	// stream packing
	localparam int OP_W          = 3;
	localparam int DATA_W        = 24;
	localparam int IN_FIELDS_W   = BYTE_W + SLOT_W + OFF_W;
	localparam int RES_W         = 2 + SLOT_W + COUNT_W + BYTE_W;

	localparam logic [SLOT_W-1:0]     LAST_SLOT   = SLOT_W'(SLOTS - 1);
	localparam logic [NAME_LEN_W-1:0] KEY_FULL    = NAME_LEN_W'(NAME_MAX);
	localparam logic [CLEN_W-1:0]     CONTENT_TOP = CLEN_W'(CONTENT_MAX);

	typedef enum logic [OP_W-1:0] {
		OP_NAME_BYTE    = 3'd0,
		OP_CREATE       = 3'd1,
		OP_CONTENT_BYTE = 3'd2,
		OP_LOOKUP       = 3'd3,
		OP_REMOVE       = 3'd4,
		OP_COUNT        = 3'd5,
		OP_READ_NAME    = 3'd6,
		OP_READ_CONTENT = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE,
		S_MATCH,
		S_COUNT,
		S_RD_ADDR,
		S_RD_DATA,
		S_RESP
	} state_t;

	typedef logic [NAME_MAX-1:0][BYTE_W-1:0] name_bytes_t;

	typedef struct packed {
		logic [NAME_LEN_W-1:0] len;
		name_bytes_t           bytes;
	} name_row_t;

	// result item; status sits in the lowest bits
	typedef struct packed {
		logic [BYTE_W-1:0]  read_byte;
		logic [COUNT_W-1:0] used_count;
		logic [SLOT_W-1:0]  slot_found;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic                   name_we;
		logic [SLOT_W-1:0]      name_waddr;
		name_row_t              name_wdata;
		logic                   clen_we;
		logic [SLOT_W-1:0]      clen_waddr;
		logic [CLEN_W-1:0]      clen_wdata;
		logic                   cont_we;
		logic [CONT_ADDR_W-1:0] cont_waddr;
		logic [BYTE_W-1:0]      cont_wdata;
		logic [SLOT_W-1:0]      rd_slot;
		logic [OFF_W-1:0]       rd_off;
	} store_req_t;

	typedef struct packed {
		name_row_t          name_row;
		logic [CLEN_W-1:0]  clen;
		logic [BYTE_W-1:0]  cont_byte;
	} store_rsp_t;

endpackage

`default_nettype wire

// File: rtl/nsts_store.sv
// Slot storage: name rows with their lengths, content lengths and content bytes.
// Three single-write memories with registered reads; types from nsts_pkg.
`default_nettype none

module nsts_store (
	input  wire logic                clk,
	input  wire nsts_pkg::store_req_t req,
	output nsts_pkg::store_rsp_t      rsp
);

	nsts_pkg::name_row_t              name_mem [nsts_pkg::SLOTS];
	logic [nsts_pkg::CLEN_W-1:0]      clen_mem [nsts_pkg::SLOTS];
	logic [nsts_pkg::BYTE_W-1:0]      cont_mem [nsts_pkg::SLOTS * (nsts_pkg::CONTENT_MAX + 1)];

	// one write port per memory, all reads addressed by the same slot
	always_ff @(posedge clk) begin
		if (req.name_we) begin
			name_mem[req.name_waddr] <= req.name_wdata;
		end
		if (req.clen_we) begin
			clen_mem[req.clen_waddr] <= req.clen_wdata;
		end
		if (req.cont_we) begin
			cont_mem[req.cont_waddr] <= req.cont_wdata;
		end
		rsp.name_row  <= name_mem[req.rd_slot];
		rsp.clen      <= clen_mem[req.rd_slot];
		rsp.cont_byte <= cont_mem[{req.rd_slot, req.rd_off}];
	end

endmodule

`default_nettype wire

// File: rtl/nsts_cmp.sv
// Name compare unit: one stored name row against the key buffer per use.
// Length must agree and every byte below the key length must match; uses nsts_pkg.
`default_nettype none

module nsts_cmp (
	input  wire nsts_pkg::name_row_t                row,
	input  wire nsts_pkg::name_bytes_t              key,
	input  wire logic [nsts_pkg::NAME_LEN_W-1:0]    key_len,
	output logic                                    eq
);

	always_comb begin
		eq = (row.len == key_len);
		for (int i = 0; i < nsts_pkg::NAME_MAX; i++) begin
			if ((nsts_pkg::NAME_LEN_W'(i) < key_len) && (row.bytes[i] != key[i])) begin
				eq = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/named_slot_table_store_top.sv
// Named slot table store top level: sequencer, key buffer, slot marks, output register.
// Instantiates nsts_store and nsts_cmp; types and constants from nsts_pkg.
// Name byte and content byte give no result. Create scans the used marks one slot
// per cycle, lookup and remove compare one stored name per cycle through the shared
// compare unit, count walks the marks, and reads address the memories and then take
// the registered data; a response state hands the result to the output register once
// it is free. One transaction at a time. Reset clears control state only; the memories
// start undefined and need no clearing pass.
`default_nettype none

module named_slot_table_store_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [nsts_pkg::DATA_W-1:0]   s_axis_tdata,  // data_byte[7:0], slot[12:8], offset[20:13]
	input  wire logic [nsts_pkg::OP_W-1:0]     s_axis_tuser,  // operation[2:0]
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [nsts_pkg::DATA_W-1:0]        m_axis_tdata   // status[1:0], slot_found[6:2],
	                                                          // used_count[12:7], read_byte[20:13]
);

	// unpack the input transaction
	nsts_pkg::op_t                  in_op;
	logic [nsts_pkg::BYTE_W-1:0]    in_data;
	logic [nsts_pkg::SLOT_W-1:0]    in_slot;
	logic [nsts_pkg::OFF_W-1:0]     in_off;
	logic                           accept;

	assign in_op   = nsts_pkg::op_t'(s_axis_tuser);
	assign in_data = s_axis_tdata[nsts_pkg::BYTE_W-1:0];
	assign in_slot = s_axis_tdata[nsts_pkg::BYTE_W +: nsts_pkg::SLOT_W];
	assign in_off  = s_axis_tdata[nsts_pkg::BYTE_W + nsts_pkg::SLOT_W +: nsts_pkg::OFF_W];
	assign accept  = s_axis_tvalid && s_axis_tready;

	// control state
	nsts_pkg::state_t                   st_q, state_d;
	nsts_pkg::op_t                      op_q;
	logic [nsts_pkg::SLOTS-1:0]         used_q;
	logic [nsts_pkg::SLOT_W-1:0]        idx_q;
	logic                               issue_done_q;
	logic                               pend_s1;
	logic [nsts_pkg::SLOT_W-1:0]        idx_s1;
	logic [nsts_pkg::OFF_W-1:0]         off_q;
	logic [nsts_pkg::COUNT_W-1:0]       cnt_q;
	logic [nsts_pkg::NAME_LEN_W-1:0]    key_len_q;
	logic                               key_ovf_q;
	nsts_pkg::name_bytes_t              key_bytes_q;
	logic                               open_vld_q;
	logic [nsts_pkg::SLOT_W-1:0]        open_slot_q;
	logic [nsts_pkg::CLEN_W-1:0]        open_len_q;
	nsts_pkg::result_t                  res_q, res_d;
	nsts_pkg::result_t                  out_res_q;
	logic                               out_valid_q;

	// sequencer strobes
	logic res_ld, key_push, key_clear, app_do, new_hit, new_full, rm_hit;
	logic idx_clr, idx_inc, rd_load, out_load;

	nsts_pkg::store_req_t req;
	nsts_pkg::store_rsp_t rsp;
	logic                 cmp_eq;
	logic                 match_hit;

	nsts_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	// the one compare unit, fed with the row read out in the cycle before
	nsts_cmp u_cmp (
		.row     (rsp.name_row),
		.key     (key_bytes_q),
		.key_len (key_len_q),
		.eq      (cmp_eq)
	);

	assign match_hit = pend_s1 && used_q[idx_s1] && cmp_eq;

	// memory ports: create writes the key as a whole row, content bytes append at the
	// open slot, and every read is addressed by the scan index and the held offset
	always_comb begin
		req            = '0;
		req.name_we    = new_hit;
		req.name_waddr = idx_q;
		req.name_wdata = '{len: key_len_q, bytes: key_bytes_q};
		req.clen_we    = new_hit || app_do;
		req.clen_waddr = new_hit ? idx_q : open_slot_q;
		req.clen_wdata = new_hit ? '0 : open_len_q + nsts_pkg::CLEN_W'(1);
		req.cont_we    = app_do;
		req.cont_waddr = {open_slot_q, open_len_q};
		req.cont_wdata = in_data;
		req.rd_slot    = idx_q;
		req.rd_off     = off_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= nsts_pkg::S_IDLE;
		end else begin
			st_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = st_q;
		res_d     = '0;
		res_ld    = 1'b0;
		key_push  = 1'b0;
		key_clear = 1'b0;
		app_do    = 1'b0;
		new_hit   = 1'b0;
		new_full  = 1'b0;
		rm_hit    = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		rd_load   = 1'b0;
		out_load  = 1'b0;
		case (st_q)
			nsts_pkg::S_IDLE: begin
				if (accept) begin
					case (in_op)
						nsts_pkg::OP_NAME_BYTE: begin
							key_push = 1'b1;
						end
						nsts_pkg::OP_CREATE: begin
							idx_clr = 1'b1;
							state_d = nsts_pkg::S_FREE;
						end
						nsts_pkg::OP_CONTENT_BYTE: begin
							// drop the byte with no open slot or a full content
							app_do = open_vld_q && (open_len_q < nsts_pkg::CONTENT_TOP);
						end
						nsts_pkg::OP_LOOKUP, nsts_pkg::OP_REMOVE: begin
							if (key_ovf_q) begin
								// an overflowed key never matches
								res_d.status = nsts_pkg::ST_NOT_FOUND;
								res_ld       = 1'b1;
								key_clear    = 1'b1;
								state_d      = nsts_pkg::S_RESP;
							end else begin
								idx_clr = 1'b1;
								state_d = nsts_pkg::S_MATCH;
							end
						end
						nsts_pkg::OP_COUNT: begin
							idx_clr = 1'b1;
							state_d = nsts_pkg::S_COUNT;
						end
						default: begin
							rd_load = 1'b1;
							state_d = nsts_pkg::S_RD_ADDR;
						end
					endcase
				end
			end
			nsts_pkg::S_FREE: begin
				if (!used_q[idx_q]) begin
					new_hit          = 1'b1;
					key_clear        = 1'b1;
					res_d.slot_found = idx_q;
					res_ld           = 1'b1;
					state_d          = nsts_pkg::S_RESP;
				end else if (idx_q == nsts_pkg::LAST_SLOT) begin
					new_full     = 1'b1;
					key_clear    = 1'b1;
					res_d.status = nsts_pkg::ST_FULL;
					res_ld       = 1'b1;
					state_d      = nsts_pkg::S_RESP;
				end else begin
					idx_inc = 1'b1;
				end
			end
			nsts_pkg::S_MATCH: begin
				if (match_hit) begin
					rm_hit           = (op_q == nsts_pkg::OP_REMOVE);
					key_clear        = 1'b1;
					res_d.slot_found = idx_s1;
					res_ld           = 1'b1;
					state_d          = nsts_pkg::S_RESP;
				end else if (pend_s1 && (idx_s1 == nsts_pkg::LAST_SLOT)) begin
					key_clear    = 1'b1;
					res_d.status = nsts_pkg::ST_NOT_FOUND;
					res_ld       = 1'b1;
					state_d      = nsts_pkg::S_RESP;
				end
			end
			nsts_pkg::S_COUNT: begin
				if (idx_q == nsts_pkg::LAST_SLOT) begin
					res_d.used_count = cnt_q + nsts_pkg::COUNT_W'(used_q[idx_q]);
					res_ld           = 1'b1;
					state_d          = nsts_pkg::S_RESP;
				end else begin
					idx_inc = 1'b1;
				end
			end
			nsts_pkg::S_RD_ADDR: begin
				state_d = nsts_pkg::S_RD_DATA;
			end
			nsts_pkg::S_RD_DATA: begin
				res_ld  = 1'b1;
				state_d = nsts_pkg::S_RESP;
				if (!used_q[idx_q]) begin
					res_d.status = nsts_pkg::ST_NOT_FOUND;
				end else if (op_q == nsts_pkg::OP_READ_NAME) begin
					if (off_q < nsts_pkg::OFF_W'(rsp.name_row.len)) begin
						res_d.read_byte = rsp.name_row.bytes[off_q[nsts_pkg::NAME_IDX_W-1:0]];
					end
				end else begin
					if (off_q < rsp.clen) begin
						res_d.read_byte = rsp.cont_byte;
					end
				end
			end
			nsts_pkg::S_RESP: begin
				// hold the result until the output register is free
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = nsts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nsts_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer datapath and table marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= nsts_pkg::OP_NAME_BYTE;
			used_q       <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
			idx_s1       <= '0;
			off_q        <= '0;
			cnt_q        <= '0;
			key_len_q    <= '0;
			key_ovf_q    <= 1'b0;
			open_vld_q   <= 1'b0;
			open_slot_q  <= '0;
			open_len_q   <= '0;
			res_q        <= '0;
			out_res_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				op_q <= in_op;
			end

			// scan index: reads load it with the slot, scans count it up
			if (rd_load) begin
				idx_q <= in_slot;
				off_q <= in_off;
			end else if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + nsts_pkg::SLOT_W'(1);
			end else if ((st_q == nsts_pkg::S_MATCH) && !issue_done_q) begin
				if (idx_q == nsts_pkg::LAST_SLOT) begin
					issue_done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + nsts_pkg::SLOT_W'(1);
				end
			end
			if (idx_clr) begin
				issue_done_q <= 1'b0;
			end

			// tag of the row now coming out of the name memory
			pend_s1 <= (st_q == nsts_pkg::S_MATCH) && !issue_done_q;
			idx_s1  <= idx_q;

			if (idx_clr) begin
				cnt_q <= '0;
			end else if (st_q == nsts_pkg::S_COUNT) begin
				cnt_q <= cnt_q + nsts_pkg::COUNT_W'(used_q[idx_q]);
			end

			// key buffer control
			if (key_clear) begin
				key_len_q <= '0;
				key_ovf_q <= 1'b0;
			end else if (key_push) begin
				if (key_len_q < nsts_pkg::KEY_FULL) begin
					key_len_q <= key_len_q + nsts_pkg::NAME_LEN_W'(1);
				end else begin
					key_ovf_q <= 1'b1;
				end
			end

			// used marks and the slot open for content
			if (new_hit) begin
				used_q[idx_q] <= 1'b1;
				open_vld_q    <= 1'b1;
				open_slot_q   <= idx_q;
				open_len_q    <= '0;
			end
			if (new_full) begin
				open_vld_q <= 1'b0;
			end
			if (rm_hit) begin
				used_q[idx_s1] <= 1'b0;
				if (open_slot_q == idx_s1) begin
					open_vld_q <= 1'b0;
				end
			end
			if (app_do) begin
				open_len_q <= open_len_q + nsts_pkg::CLEN_W'(1);
			end

			if (res_ld) begin
				res_q <= res_d;
			end

			// output register: advance on load, drop once taken
			if (out_load) begin
				out_res_q   <= res_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// key bytes are payload and need no reset
	always_ff @(posedge clk) begin
		if (key_push && (key_len_q < nsts_pkg::KEY_FULL)) begin
			key_bytes_q[key_len_q] <= in_data;
		end
	end

	assign s_axis_tready = (st_q == nsts_pkg::S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(nsts_pkg::DATA_W - nsts_pkg::RES_W){1'b0}}, out_res_q};

	// the open slot is always a used slot
	a_open_used: assert property (@(posedge clk) disable iff (!arst_n)
		open_vld_q |-> used_q[open_slot_q])
		else $error("open slot is not marked used");

	// overflow is only flagged once the key buffer is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		key_ovf_q |-> (key_len_q == nsts_pkg::KEY_FULL))
		else $error("key overflow with room left in the key buffer");

	// a name scan never runs with an overflowed key
	a_match_key: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == nsts_pkg::S_MATCH) |-> !key_ovf_q)
		else $error("name scan started with an overflowed key");

	// failed operations report slot zero
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == nsts_pkg::S_RESP) && (res_q.status != nsts_pkg::ST_OK))
		|-> (res_q.slot_found == '0))
		else $error("failed result carries a slot");

	// a finished create leaves its slot used and open
	a_create_open: assert property (@(posedge clk) disable iff (!arst_n)
		new_hit |=> (open_vld_q && used_q[open_slot_q] && (open_len_q == '0)))
		else $error("created slot not opened");

endmodule

`default_nettype wire

// File: dv/nsts_checker.sv
// Scoreboard for the named slot table store: watches both stream channels,
// keeps its own copy of the table, predicts each result and compares it field by field.
// Depends on nsts_pkg for widths, operation codes, status codes and the result layout.

module nsts_checker
	import nsts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,
	input  wire logic [OP_W-1:0]   s_tuser,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [DATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending,
	output int                     checked_count,
	output int                     full_count,
	output int                     hit_count
);

	localparam int MAX_REPORTS = 40;

	bit                slot_used [SLOTS];
	logic [BYTE_W-1:0] slot_name [SLOTS][NAME_MAX];
	int                name_len  [SLOTS];
	logic [BYTE_W-1:0] slot_data [SLOTS][CONTENT_MAX];
	int                data_len  [SLOTS];
	logic [BYTE_W-1:0] key_bytes [NAME_MAX];
	int                key_len;
	bit                key_overflowed;
	int                open_slot;
	result_t           expected_results [$];

	task automatic report_mismatch(string what, int got, int want);
		if (fail_count < MAX_REPORTS)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// lowest used slot whose name equals the key, SLOTS when none does
	function automatic int find_name();
		bit same;
		if (key_overflowed)
			return SLOTS;
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_used[s] && name_len[s] == key_len) begin
				same = 1'b1;
				for (int i = 0; i < key_len; i++)
					if (slot_name[s][i] !== key_bytes[i])
						same = 1'b0;
				if (same)
					return s;
			end
		end
		return SLOTS;
	endfunction

	task automatic predict_item(input op_t op, input logic [BYTE_W-1:0] data,
			input logic [SLOT_W-1:0] rd_slot, input logic [OFF_W-1:0] off);
		result_t res;
		int      s;
		int      n;
		res = '0;
		case (op)
			OP_NAME_BYTE: begin
				if (key_len < NAME_MAX) begin
					key_bytes[key_len] = data;
					key_len++;
				end else begin
					key_overflowed = 1'b1;
				end
				return;
			end
			OP_CONTENT_BYTE: begin
				if (open_slot < SLOTS && data_len[open_slot] < CONTENT_MAX) begin
					slot_data[open_slot][data_len[open_slot]] = data;
					data_len[open_slot]++;
				end
				return;
			end
			OP_CREATE: begin
				s = 0;
				while (s < SLOTS && slot_used[s])
					s++;
				if (s < SLOTS) begin
					for (int i = 0; i < key_len; i++)
						slot_name[s][i] = key_bytes[i];
					name_len[s]   = key_len;
					data_len[s]   = 0;
					slot_used[s]  = 1'b1;
					open_slot     = s;
					res.slot_found = SLOT_W'(s);
				end else begin
					open_slot  = SLOTS;
					res.status = ST_FULL;
					full_count++;
				end
				key_len        = 0;
				key_overflowed = 1'b0;
			end
			OP_LOOKUP, OP_REMOVE: begin
				s = find_name();
				if (s < SLOTS) begin
					res.slot_found = SLOT_W'(s);
					hit_count++;
					if (op == OP_REMOVE) begin
						slot_used[s] = 1'b0;
						if (open_slot == s)
							open_slot = SLOTS;
					end
				end else begin
					res.status = ST_NOT_FOUND;
				end
				key_len        = 0;
				key_overflowed = 1'b0;
			end
			OP_COUNT: begin
				n = 0;
				for (int i = 0; i < SLOTS; i++)
					n += slot_used[i];
				res.used_count = COUNT_W'(n);
			end
			default: begin
				if (!slot_used[rd_slot])
					res.status = ST_NOT_FOUND;
				else if (op == OP_READ_NAME) begin
					if (off < name_len[rd_slot])
						res.read_byte = slot_name[rd_slot][off];
				end else if (off < data_len[rd_slot]) begin
					res.read_byte = slot_data[rd_slot][off];
				end
			end
		endcase
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_used[i] = 1'b0;
			key_len        = 0;
			key_overflowed = 1'b0;
			open_slot      = SLOTS;
			expected_results.delete();
			fail_count     = 0;
			checked_count  = 0;
			full_count     = 0;
			hit_count      = 0;
			pending       <= 0;
		end else begin
			// a result can leave in the same cycle that a new transaction is taken, so check first
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RES_W-1:0]);
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending", int'(got), -1);
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (got.status !== want.status)
						report_mismatch("status", int'(got.status), int'(want.status));
					if (got.slot_found !== want.slot_found)
						report_mismatch("slot_found", got.slot_found, want.slot_found);
					if (got.used_count !== want.used_count)
						report_mismatch("used_count", got.used_count, want.used_count);
					if (got.read_byte !== want.read_byte)
						report_mismatch("read_byte", got.read_byte, want.read_byte);
				end
			end
			if (s_tvalid && s_tready)
				predict_item(op_t'(s_tuser), s_tdata[7:0], s_tdata[12:8], s_tdata[20:13]);
			pending <= expected_results.size();
		end
	end

endmodule

// File: dv/tb.sv
// Testbench top for the named slot table store: clock, reset, stimulus and verdict.
// Depends on nsts_pkg, named_slot_table_store_top and the nsts_checker scoreboard.

module tb;
	import nsts_pkg::*;

	localparam int POOL         = 10;      // names reused so lookups and removes hit
	localparam int POOL_DEPTH   = 40;
	localparam int LONG_HOLD    = 300;     // cycles the receiver holds off once
	localparam int DRAIN        = 40;      // a little more than the longest scan
	localparam int CYCLE_LIMIT  = 600000;
	localparam int TARGET_ITEMS = 850;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic [OP_W-1:0]   s_axis_tuser  = OP_COUNT;
	logic              s_axis_tready;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;

	int fail_count;
	int pending;
	int checked_count;
	int full_count;
	int hit_count;
	int items_sent = 0;
	int cycles     = 0;
	bit long_hold_req = 1'b0;

	logic [BYTE_W-1:0] pool_bytes [POOL][POOL_DEPTH];
	int                pool_len   [POOL];

	named_slot_table_store_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	nsts_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_axis_tvalid),
		.s_tready      (s_axis_tready),
		.s_tdata       (s_axis_tdata),
		.s_tuser       (s_axis_tuser),
		.m_tvalid      (m_axis_tvalid),
		.m_tready      (m_axis_tready),
		.m_tdata       (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.full_count    (full_count),
		.hit_count     (hit_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: give up if the run hangs.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
		$display("Regression FAIL");
		$finish;
	end

	// Idle length shared by both sides: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Receiver: random ready bursts and stalls; honor one long hold-off on request.
	initial begin
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < 60) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// Offer one transaction after a random gap and hold it until accepted.
	// Keep tvalid high across back-to-back transactions.
	task automatic send(input op_t op, input logic [BYTE_W-1:0] data,
			input logic [SLOT_W-1:0] slot, input logic [OFF_W-1:0] off);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(DATA_W - IN_FIELDS_W){1'b0}}, off, slot, data};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Unused fields carry random junk so every input bit toggles.
	task automatic send_op(input op_t op);
		send(op, BYTE_W'($urandom), SLOT_W'($urandom), OFF_W'($urandom));
	endtask

	task automatic send_key(input int p);
		for (int i = 0; i < pool_len[p]; i++)
			send(OP_NAME_BYTE, pool_bytes[p][i], SLOT_W'($urandom), OFF_W'($urandom));
	endtask

	task automatic keyed_op(input op_t op, input int p);
		send_key(p);
		send_op(op);
	endtask

	task automatic send_content(input int n);
		repeat (n) send_op(OP_CONTENT_BYTE);
	endtask

	task automatic read_at(input op_t op, input int slot, input int off);
		send(op, BYTE_W'($urandom), SLOT_W'(slot), OFF_W'(off));
	endtask

	task automatic renew_name(input int p, input int len);
		for (int i = 0; i < len; i++)
			pool_bytes[p][i] = BYTE_W'($urandom);
		pool_len[p] = len;
	endtask

	// One random sequence; create and remove weights steer how full the table runs.
	task automatic random_sequence(input int create_pct, input int remove_pct);
		int r;
		int p;
		int lim;
		r   = $urandom_range(0, 99);
		p   = $urandom_range(0, POOL - 1);
		lim = create_pct + remove_pct;
		if (r < create_pct) begin
			if ($urandom_range(0, 9) == 0)
				renew_name(p, $urandom_range(0, 34));
			keyed_op(OP_CREATE, p);
			send_content($urandom_range(0, 8));
		end else if (r < lim) begin
			keyed_op(OP_REMOVE, p);
		end else if (r < lim + 12) begin
			keyed_op(OP_LOOKUP, p);
		end else if (r < lim + 16) begin
			send_op(OP_COUNT);
		end else if (r < lim + 26) begin
			read_at(OP_READ_NAME, $urandom_range(0, 31),
				($urandom_range(0, 9) < 7) ? $urandom_range(0, 32) : $urandom_range(0, 255));
		end else if (r < lim + 36) begin
			r = $urandom_range(0, 9);
			read_at(OP_READ_CONTENT, $urandom_range(0, 31),
				(r < 6) ? $urandom_range(0, 12) :
				(r < 8) ? $urandom_range(0, 255) : $urandom_range(240, 255));
		end else if ($urandom_range(0, 1) == 0) begin
			// stray content bytes, dropped when no slot is open
			send_content($urandom_range(1, 3));
		end else begin
			// broken name: leftover bytes spoil the next key
			repeat ($urandom_range(1, 4)) send_op(OP_NAME_BYTE);
		end
	endtask

	initial begin
		int base;
		int create_pct [3];
		int remove_pct [3];
		create_pct = '{40, 15, 25};
		remove_pct = '{10, 35, 25};

		// name pool: empty, full length, too long, a single zero byte, then short ones
		renew_name(0, 0);
		renew_name(1, NAME_MAX);
		pool_bytes[1][0]  = 8'hFF;
		pool_bytes[1][30] = 8'h00;
		renew_name(2, NAME_MAX + 4);
		renew_name(3, 1);
		pool_bytes[3][0] = 8'h00;
		for (int p = 4; p < POOL; p++)
			renew_name(p, $urandom_range(1, 12));

		// hold reset, then release it once
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, missing names and reads of unused slots.
		send_op(OP_COUNT);
		read_at(OP_READ_NAME, 0, 0);
		keyed_op(OP_LOOKUP, 0);
		send(OP_CONTENT_BYTE, 8'hFF, '0, '0);

		// empty name into slot 0, content with zero and all-ones bytes
		keyed_op(OP_CREATE, 0);
		send(OP_CONTENT_BYTE, 8'h00, '1, '1);
		send(OP_CONTENT_BYTE, 8'hFF, '0, '0);
		read_at(OP_READ_CONTENT, 0, 1);
		read_at(OP_READ_CONTENT, 0, 2);
		read_at(OP_READ_NAME, 0, 0);

		// overflowed name is kept cut short but never matches
		keyed_op(OP_CREATE, 2);
		keyed_op(OP_LOOKUP, 2);
		read_at(OP_READ_NAME, 1, NAME_MAX - 1);
		read_at(OP_READ_NAME, 1, NAME_MAX);

		// longest name that fits
		keyed_op(OP_CREATE, 1);
		keyed_op(OP_LOOKUP, 1);

		// duplicate names: the lowest match goes first; removing the open slot closes it
		keyed_op(OP_CREATE, 0);
		keyed_op(OP_REMOVE, 0);
		keyed_op(OP_LOOKUP, 0);
		keyed_op(OP_REMOVE, 0);
		send_op(OP_CONTENT_BYTE);
		read_at(OP_READ_CONTENT, 3, 0);

		// content past the limit is dropped
		keyed_op(OP_CREATE, 3);
		send_content(CONTENT_MAX + 3);
		read_at(OP_READ_CONTENT, 0, CONTENT_MAX - 1);
		read_at(OP_READ_CONTENT, 0, CONTENT_MAX);
		send_op(OP_COUNT);
		read_at(OP_READ_CONTENT, SLOTS - 1, 255);

		// Random: fill the table, drain it, then run balanced, up to the item budget.
		base = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			// let the block fill up behind a stalled receiver
			if (phase == 1)
				long_hold_req = 1'b1;
			while (items_sent < base + (phase + 1) * (TARGET_ITEMS - base) / 3)
				random_sequence(create_pct[phase], remove_pct[phase]);
			// pause the sender until every result is back
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while (pending != 0);
		end

		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results,", items_sent, checked_count);
		$display("including %0d table-full replies and %0d name matches.", full_count, hit_count);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/nsts_pkg.sv
rtl/nsts_store.sv
rtl/nsts_cmp.sv
rtl/named_slot_table_store_top.sv
dv/nsts_checker.sv
dv/tb.sv
